[hdl/arcp_pkg.sv]
// ----------------------------------------------------------------------------
// arcp_pkg
// Shared types and constants of the adaptive replacement cache directory.
// ----------------------------------------------------------------------------
package arcp_pkg;

    localparam int CAPACITY_MAX_DEF = 64;
    localparam int KEY_BITS_DEF     = 32;
    localparam int CFG_W            = 7;
    localparam int CFG_RESET        = 10;
    localparam int KIND_W           = 2;
    localparam int HIT_W            = 3;

    localparam logic [HIT_W-1:0] HIT_NONE = 3'd0;

    // list codes; head is the LRU end
    typedef enum logic [1:0] {
        L_T1 = 2'd0,
        L_T2 = 2'd1,
        L_B1 = 2'd2,
        L_B2 = 2'd3
    } t_list;

    typedef enum logic [1:0] {
        K_ACCESS = 2'd0,
        K_REMOVE = 2'd1,
        K_EVICT  = 2'd2
    } t_kind;

    // operation applied by all cells together
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_MOVE = 2'd1,
        OP_DEL  = 2'd2,
        OP_INS  = 2'd3
    } t_op;

    // how the addressed cell is chosen
    typedef enum logic {
        SM_KEY = 1'b0,
        SM_LRU = 1'b1
    } t_mode;

    typedef struct packed {
        t_op   op;
        t_mode mode;
        t_list lst;
        t_list to;
    } t_cmd;

    typedef struct packed {
        logic  found;
        t_list lst;
    } t_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_MOVE,
        S_DIV,
        S_ADAPT,
        S_REPL,
        S_MISS,
        S_FULL,
        S_INS,
        S_FORCE,
        S_DONE
    } t_state;

    // hit class of a list: list code plus one
    function automatic logic [HIT_W-1:0] hit_of(input t_list l);
        hit_of = {1'b0, l} + 3'd1;
    endfunction

endpackage

[hdl/arcp_if.sv]
// ----------------------------------------------------------------------------
// arcp_if
// Channel interfaces: request, response and configuration write.
// ----------------------------------------------------------------------------
interface arcp_in_if #(parameter int KEY_BITS = 32);
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [KEY_BITS-1:0] key;
    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

interface arcp_out_if #(parameter int KEY_BITS = 32, parameter int P_W = 7);
    logic                valid;
    logic                ready;
    logic [2:0]          hit_class;
    logic                evict_valid;
    logic [KEY_BITS-1:0] evict_key;
    logic                cache_nonempty;
    logic [P_W-1:0]      adapt_target;
    modport source (output valid, output hit_class, output evict_valid, output evict_key,
                    output cache_nonempty, output adapt_target, input ready);
    modport sink   (input valid, input hit_class, input evict_valid, input evict_key,
                    input cache_nonempty, input adapt_target, output ready);
endinterface

interface arcp_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/arcp_cell.sv]
// ----------------------------------------------------------------------------
// arcp_cell
// One directory entry: key, list and rank within its list (0 = LRU).
// Valid entries stay packed at the low end; a delete shifts upper cells down.
// ----------------------------------------------------------------------------
module arcp_cell #(
    parameter int KEY_BITS = 32,
    parameter int IDX_W    = 7,
    parameter int IDX      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  arcp_pkg::t_cmd        i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic                  i_found,
    input  arcp_pkg::t_list       i_sel_list,
    input  logic [IDX_W-1:0]      i_sel_rank,
    input  logic [IDX_W-1:0]      i_sel_idx,
    input  logic [IDX_W-1:0]      i_new_rank,
    input  logic [IDX_W-1:0]      i_ins_idx,
    input  logic                  i_nb_valid,
    input  logic [KEY_BITS-1:0]   i_nb_key,
    input  arcp_pkg::t_list       i_nb_list,
    input  logic [IDX_W-1:0]      i_nb_rank,
    output logic                  o_sel,
    output logic                  o_valid,
    output logic [KEY_BITS-1:0]   o_key,
    output arcp_pkg::t_list       o_list,
    output logic [IDX_W-1:0]      o_rank,
    output logic [IDX_W-1:0]      o_up_rank
);
    import arcp_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                r_valid, n_valid;
    logic [KEY_BITS-1:0] r_key, n_key;
    t_list               r_list, n_list;
    logic [IDX_W-1:0]    r_rank, n_rank;
    logic                shrink;

    // selection for this cycle's operation
    always_comb begin
        o_sel = 1'b0;
        if (r_valid) begin
            if (i_cmd.mode == SM_KEY) begin
                o_sel = (r_key == i_key);
            end else begin
                o_sel = (r_list == i_cmd.lst) && (r_rank == '0);
            end
        end
    end

    // entries behind the removed one in the same list move up by one
    assign shrink = i_found && r_valid && (i_cmd.op == OP_MOVE || i_cmd.op == OP_DEL)
                    && (r_list == i_sel_list) && (r_rank > i_sel_rank);
    assign o_up_rank = shrink ? (r_rank - 1'b1) : r_rank;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_list  = r_list;
        n_rank  = o_up_rank;
        case (i_cmd.op)
            OP_MOVE: begin
                if (o_sel) begin
                    n_list = i_cmd.to;
                    n_rank = i_new_rank;
                end
            end
            OP_DEL: begin
                if (i_found && (MY_IDX >= i_sel_idx)) begin
                    n_valid = i_nb_valid;
                    n_key   = i_nb_key;
                    n_list  = i_nb_list;
                    n_rank  = i_nb_rank;
                end
            end
            OP_INS: begin
                if (MY_IDX == i_ins_idx) begin
                    n_valid = 1'b1;
                    n_key   = i_key;
                    n_list  = L_T1;
                    n_rank  = i_new_rank;
                end
            end
            default: begin
                n_rank = r_rank;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_list <= n_list;
        r_rank <= n_rank;
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_list  = r_list;
    assign o_rank  = r_rank;

endmodule

[hdl/arcp_array.sv]
// ----------------------------------------------------------------------------
// arcp_array
// Row of directory cells; each cell hands its entry to its lower neighbor.
// The one-hot selected entry is gathered by an OR reduction.
// ----------------------------------------------------------------------------
module arcp_array #(
    parameter int KEY_BITS = 32,
    parameter int ENTRIES  = 128,
    parameter int IDX_W    = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  arcp_pkg::t_cmd        i_cmd,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [IDX_W-1:0]      i_new_rank,
    input  logic [IDX_W-1:0]      i_ins_idx,
    output arcp_pkg::t_sel        o_sel,
    output logic [KEY_BITS-1:0]   o_sel_key
);
    import arcp_pkg::*;

    logic                c_sel   [ENTRIES];
    logic                c_valid [ENTRIES+1];
    logic [KEY_BITS-1:0] c_key   [ENTRIES+1];
    t_list               c_list  [ENTRIES+1];
    logic [IDX_W-1:0]    c_rank  [ENTRIES];
    logic [IDX_W-1:0]    c_up    [ENTRIES+1];

    logic                found;
    logic [1:0]          sel_list;
    logic [IDX_W-1:0]    sel_rank;
    logic [IDX_W-1:0]    sel_idx;
    logic [KEY_BITS-1:0] sel_key;

    // empty slot past the top cell
    assign c_valid[ENTRIES] = 1'b0;
    assign c_key[ENTRIES]   = '0;
    assign c_list[ENTRIES]  = L_T1;
    assign c_up[ENTRIES]    = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        arcp_cell #(
            .KEY_BITS (KEY_BITS),
            .IDX_W    (IDX_W),
            .IDX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (i_cmd),
            .i_key      (i_key),
            .i_found    (found),
            .i_sel_list (t_list'(sel_list)),
            .i_sel_rank (sel_rank),
            .i_sel_idx  (sel_idx),
            .i_new_rank (i_new_rank),
            .i_ins_idx  (i_ins_idx),
            .i_nb_valid (c_valid[g+1]),
            .i_nb_key   (c_key[g+1]),
            .i_nb_list  (c_list[g+1]),
            .i_nb_rank  (c_up[g+1]),
            .o_sel      (c_sel[g]),
            .o_valid    (c_valid[g]),
            .o_key      (c_key[g]),
            .o_list     (c_list[g]),
            .o_rank     (c_rank[g]),
            .o_up_rank  (c_up[g])
        );
    end

    // OR-gather of the selected cell
    always_comb begin
        found    = 1'b0;
        sel_list = '0;
        sel_rank = '0;
        sel_idx  = '0;
        sel_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (c_sel[i]) begin
                found    = 1'b1;
                sel_list = sel_list | c_list[i];
                sel_rank = sel_rank | c_rank[i];
                sel_idx  = sel_idx | IDX_W'(i);
                sel_key  = sel_key | c_key[i];
            end
        end
    end

    assign o_sel.found = found;
    assign o_sel.lst   = t_list'(sel_list);
    assign o_sel_key   = sel_key;

endmodule

[hdl/arcp_div.sv]
// ----------------------------------------------------------------------------
// arcp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module arcp_div #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic [W-1:0] o_quot
);
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_den, n_den;
    logic [W:0]    rem_sh;

    always_comb begin
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        rem_sh = {r_rem, r_quo[W-1]};
        if (i_start) begin
            n_cnt = CW'(W);
            n_quo = i_num;
            n_rem = '0;
            n_den = i_den;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = W'(rem_sh - {1'b0, r_den});
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = W'(rem_sh);
                n_quo = {r_quo[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quo;

endmodule

[hdl/adaptive_replacement_cache_policy_top.sv]
// A ghost hit waits for the serial divider; output stalls hold back the result.
// Throughput: one request at a time; the next is taken once the sequencer is
// back in idle, which it enters as the result is loaded. Each step is one broadcast.
// Reset: synchronous active low; all lists empty, target 0, cache_size 10.
// ----------------------------------------------------------------------------
// adaptive_replacement_cache_policy_top
// ARC directory: sequencer, list counts, target adaptation and cell row.
// ----------------------------------------------------------------------------
module adaptive_replacement_cache_policy_top #(
    parameter int CAPACITY_MAX = arcp_pkg::CAPACITY_MAX_DEF,
    parameter int KEY_BITS     = arcp_pkg::KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    arcp_in_if.sink     i_req,
    arcp_out_if.source  o_rsp,
    arcp_cfg_if.sink    i_cfg
);
    import arcp_pkg::*;

    localparam int ENTRIES = 2 * CAPACITY_MAX;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int P_W     = $clog2(CAPACITY_MAX + 1);
    localparam int SW      = CNT_W + 1;

    t_state              r_state, n_state, r_ret, n_ret;
    logic [1:0]          r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic [HIT_W-1:0]    r_hc, n_hc;
    logic                r_ev_v, n_ev_v;
    logic [KEY_BITS-1:0] r_ev_k, n_ev_k;
    logic [P_W-1:0]      r_p, n_p;
    logic [CFG_W-1:0]    r_cfg;
    logic [CNT_W-1:0]    r_cnt [4];
    logic [CNT_W-1:0]    n_cnt [4];
    logic                r_in_b2, n_in_b2;

    logic                r_out_v;
    logic [HIT_W-1:0]    r_out_hc;
    logic                r_out_ev;
    logic [KEY_BITS-1:0] r_out_key;
    logic                r_out_ne;
    logic [P_W-1:0]      r_out_p;
    logic                out_load;

    t_cmd                cmd;
    logic [IDX_W-1:0]    new_rank;
    t_sel                sel;
    logic [KEY_BITS-1:0] sel_key;
    logic                rep;

    logic                div_start, div_busy;
    logic [CNT_W-1:0]    div_num, div_den, div_q;

    logic [P_W-1:0]      eff_c;
    logic [SW-1:0]       c_w, t1b1, total, p_sum, d_w;
    logic                use_t1;

    // effective capacity: cache_size clamped to 1..CAPACITY_MAX
    always_comb begin
        if (r_cfg == '0) begin
            eff_c = P_W'(1);
        end else if (32'(r_cfg) > 32'(CAPACITY_MAX)) begin
            eff_c = P_W'(CAPACITY_MAX);
        end else begin
            eff_c = P_W'(r_cfg);
        end
    end

    assign c_w   = SW'(eff_c);
    assign t1b1  = SW'(r_cnt[L_T1]) + SW'(r_cnt[L_B1]);
    assign total = t1b1 + SW'(r_cnt[L_T2]) + SW'(r_cnt[L_B2]);

    // replace chooses T1 or T2 from the current counts and target
    always_comb begin
        use_t1 = (r_cnt[L_T1] != '0) &&
                 ((r_cnt[L_T1] > CNT_W'(r_p)) || (r_in_b2 && r_cnt[L_T1] == CNT_W'(r_p)));
        if (!use_t1 && r_cnt[L_T2] == '0) begin
            use_t1 = (r_cnt[L_T1] != '0);
        end
    end

    // adaptation step, at least one
    assign d_w   = (div_q == '0) ? SW'(1) : SW'(div_q);
    assign p_sum = SW'(r_p) + d_w;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_hc      = r_hc;
        n_ev_v    = r_ev_v;
        n_ev_k    = r_ev_k;
        n_p       = r_p;
        n_in_b2   = r_in_b2;
        cmd.op    = OP_NONE;
        cmd.mode  = SM_KEY;
        cmd.lst   = L_T1;
        cmd.to    = L_T1;
        rep       = 1'b0;
        div_start = 1'b0;
        div_num   = r_cnt[L_B2];
        div_den   = r_cnt[L_B1];
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_LOOK;
                    n_hc    = HIT_NONE;
                    n_ev_v  = 1'b0;
                    n_ev_k  = '0;
                end
            end
            S_LOOK: begin
                case (r_kind)
                    K_ACCESS: begin
                        if (sel.found) begin
                            n_hc = hit_of(sel.lst);
                            if (sel.lst == L_T1 || sel.lst == L_T2) begin
                                n_state = S_MOVE;
                            end else begin
                                n_in_b2   = (sel.lst == L_B2);
                                div_start = 1'b1;
                                if (sel.lst == L_B2) begin
                                    div_num = r_cnt[L_B1];
                                    div_den = r_cnt[L_B2];
                                end
                                n_state = S_DIV;
                            end
                        end else begin
                            n_state = S_MISS;
                        end
                    end
                    K_REMOVE: begin
                        cmd.op = OP_DEL;
                        rep    = 1'b1;
                        if (sel.found) begin
                            n_hc = hit_of(sel.lst);
                        end
                        n_state = S_DONE;
                    end
                    K_EVICT: begin
                        n_state = S_FORCE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_MOVE: begin
                cmd.op  = OP_MOVE;
                cmd.to  = L_T2;
                n_state = S_DONE;
            end
            S_DIV: begin
                if (!div_busy) begin
                    n_state = S_ADAPT;
                end
            end
            S_ADAPT: begin
                if (!r_in_b2) begin
                    n_p = (p_sum > c_w) ? eff_c : P_W'(p_sum);
                end else begin
                    n_p = (SW'(r_p) > d_w) ? P_W'(SW'(r_p) - d_w) : '0;
                end
                n_ret   = S_MOVE;
                n_state = S_REPL;
            end
            S_REPL: begin
                cmd.op   = OP_MOVE;
                cmd.mode = SM_LRU;
                cmd.lst  = use_t1 ? L_T1 : L_T2;
                cmd.to   = use_t1 ? L_B1 : L_B2;
                rep      = 1'b1;
                n_state  = r_ret;
            end
            S_MISS: begin
                n_in_b2 = 1'b0;
                n_ret   = S_FULL;
                cmd.mode = SM_LRU;
                if (t1b1 >= c_w) begin
                    cmd.op = OP_DEL;
                    if (SW'(r_cnt[L_T1]) < c_w) begin
                        cmd.lst = L_B1;
                        n_state = S_REPL;
                    end else begin
                        cmd.lst = L_T1;
                        rep     = 1'b1;
                        n_state = S_FULL;
                    end
                end else if (total >= c_w) begin
                    if (total >= (c_w << 1)) begin
                        cmd.op  = OP_DEL;
                        cmd.lst = L_B2;
                    end
                    n_state = S_REPL;
                end else begin
                    n_state = S_FULL;
                end
            end
            S_FULL: begin
                // pool exhausted: drop from the first nonempty of B2, B1, T2, T1
                cmd.mode = SM_LRU;
                if (total == SW'(ENTRIES)) begin
                    cmd.op = OP_DEL;
                    rep    = 1'b1;
                    if (r_cnt[L_B2] != '0) begin
                        cmd.lst = L_B2;
                    end else if (r_cnt[L_B1] != '0) begin
                        cmd.lst = L_B1;
                    end else if (r_cnt[L_T2] != '0) begin
                        cmd.lst = L_T2;
                    end else begin
                        cmd.lst = L_T1;
                    end
                end
                n_state = S_INS;
            end
            S_INS: begin
                cmd.op  = OP_INS;
                n_state = S_DONE;
            end
            S_FORCE: begin
                cmd.op   = OP_MOVE;
                cmd.mode = SM_LRU;
                rep      = 1'b1;
                if (r_cnt[L_T1] != '0) begin
                    cmd.lst = L_T1;
                    cmd.to  = L_B1;
                end else begin
                    cmd.lst = L_T2;
                    cmd.to  = L_B2;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_v || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a cache entry leaving T1/T2 is reported, last one wins
        if (rep && sel.found && (cmd.op == OP_MOVE || cmd.op == OP_DEL) &&
            (sel.lst == L_T1 || sel.lst == L_T2)) begin
            n_ev_v = 1'b1;
            n_ev_k = sel_key;
        end
    end

    // rank given to an appended entry and list count upkeep
    always_comb begin
        new_rank = IDX_W'(r_cnt[L_T1]);
        if (cmd.op == OP_MOVE) begin
            new_rank = IDX_W'(r_cnt[cmd.to] - ((cmd.to == sel.lst) ? 1'b1 : 1'b0));
        end
        for (int l = 0; l < 4; l++) begin
            n_cnt[l] = r_cnt[l];
        end
        if (sel.found && (cmd.op == OP_MOVE || cmd.op == OP_DEL)) begin
            n_cnt[sel.lst] = n_cnt[sel.lst] - 1'b1;
        end
        if (sel.found && cmd.op == OP_MOVE) begin
            n_cnt[cmd.to] = n_cnt[cmd.to] + 1'b1;
        end
        if (cmd.op == OP_INS) begin
            n_cnt[L_T1] = n_cnt[L_T1] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_p     <= '0;
            r_cfg   <= CFG_W'(CFG_RESET);
            r_out_v <= 1'b0;
            for (int l = 0; l < 4; l++) begin
                r_cnt[l] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_p     <= n_p;
            for (int l = 0; l < 4; l++) begin
                r_cnt[l] <= n_cnt[l];
            end
            if (i_cfg.valid) begin
                r_cfg <= i_cfg.data;
            end
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_hc    <= n_hc;
        r_ev_v  <= n_ev_v;
        r_ev_k  <= n_ev_k;
        r_in_b2 <= n_in_b2;
        if (r_state == S_IDLE && i_req.valid) begin
            r_kind <= i_req.kind;
            r_key  <= i_req.key;
        end
        if (out_load) begin
            r_out_hc  <= r_hc;
            r_out_ev  <= r_ev_v;
            r_out_key <= r_ev_k;
            r_out_ne  <= (r_cnt[L_T1] != '0) || (r_cnt[L_T2] != '0);
            r_out_p   <= r_p;
        end
    end

    arcp_array #(
        .KEY_BITS (KEY_BITS),
        .ENTRIES  (ENTRIES),
        .IDX_W    (IDX_W)
    ) u_array (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_key      (r_key),
        .i_new_rank (new_rank),
        .i_ins_idx  (IDX_W'(total)),
        .o_sel      (sel),
        .o_sel_key  (sel_key)
    );

    arcp_div #(
        .W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    assign i_req.ready          = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_rsp.valid          = r_out_v;
    assign o_rsp.hit_class      = r_out_hc;
    assign o_rsp.evict_valid    = r_out_ev;
    assign o_rsp.evict_key      = r_out_key;
    assign o_rsp.cache_nonempty = r_out_ne;
    assign o_rsp.adapt_target   = r_out_p;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ARC directory. Requests (access, remove,
// forced eviction, unused kind) run through several cache sizes while a
// built-in list model predicts every response field. Both channels idle in
// random bursts, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import arcp_pkg::*;

    localparam int          POOL        = 128;
    localparam int          LIMIT       = 300000;
    localparam int          DRAIN_WAIT  = 40;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] key;
    } t_req;

    typedef struct {
        logic [2:0]  hit_class;
        logic        evict_valid;
        logic [31:0] evict_key;
        logic        cache_nonempty;
        logic [6:0]  adapt_target;
    } t_rsp;

    logic clk;
    logic rst_n;

    arcp_in_if  #(.KEY_BITS(32)) req_if ();
    arcp_out_if #(.KEY_BITS(32)) rsp_if ();
    arcp_cfg_if                  cfg_if ();

    adaptive_replacement_cache_policy_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // ---------------- directory model ----------------
    logic [31:0] m_key   [POOL];
    bit          m_valid [POOL];
    t_list       m_list  [POOL];
    int          m_next  [POOL];
    int          m_prev  [POOL];
    int          m_head  [4];
    int          m_tail  [4];
    int          m_cnt   [4];
    int          m_target;
    int          m_size;
    bit          m_ev;
    logic [31:0] m_ev_key;

    function automatic int cap_eff();
        if (m_size < 1) return 1;
        if (m_size > CAPACITY_MAX_DEF) return CAPACITY_MAX_DEF;
        return m_size;
    endfunction

    function automatic int lookup(t_list l, logic [31:0] k);
        for (int i = 0; i < POOL; i++)
            if (m_valid[i] && m_list[i] == l && m_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void unlink(int i);
        int l;
        int p;
        int n;
        l = int'(m_list[i]);
        p = m_prev[i];
        n = m_next[i];
        if (m_head[l] == i) m_head[l] = n;
        else m_next[p] = n;
        if (m_tail[l] == i) m_tail[l] = p;
        else m_prev[n] = p;
        if (m_cnt[l] > 0) m_cnt[l]--;
    endfunction

    function automatic void link_mru(int i, t_list l);
        m_list[i] = l;
        m_next[i] = i;
        if (m_cnt[l] == 0) begin
            m_head[l] = i;
            m_prev[i] = i;
        end else begin
            m_next[m_tail[l]] = i;
            m_prev[i] = m_tail[l];
        end
        m_tail[l] = i;
        m_cnt[l]++;
    endfunction

    function automatic void note_evict(logic [31:0] k);
        m_ev     = 1'b1;
        m_ev_key = k;
    endfunction

    function automatic bit drop_oldest(t_list l);
        int i;
        if (m_cnt[l] == 0) return 1'b0;
        i = m_head[l];
        unlink(i);
        m_valid[i] = 1'b0;
        if (l == L_T1 || l == L_T2) note_evict(m_key[i]);
        return 1'b1;
    endfunction

    function automatic void demote(t_list from, t_list to);
        int i;
        if (m_cnt[from] == 0) return;
        i = m_head[from];
        unlink(i);
        link_mru(i, to);
        note_evict(m_key[i]);
    endfunction

    function automatic void make_room(bit in_b2);
        int  t1;
        bit  pick_t1;
        t1 = m_cnt[L_T1];
        pick_t1 = t1 >= 1 && (t1 > m_target || (in_b2 && t1 == m_target));
        if (!pick_t1 && m_cnt[L_T2] == 0) pick_t1 = t1 >= 1;
        if (pick_t1) demote(L_T1, L_B1);
        else if (m_cnt[L_T2] > 0) demote(L_T2, L_B2);
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < POOL; i++)
            if (!m_valid[i]) return i;
        return -1;
    endfunction

    function automatic int arc_access(logic [31:0] k);
        int  i;
        int  d;
        int  c;
        int  t1;
        int  t2;
        int  b1;
        int  b2;
        bit  dummy;
        c  = cap_eff();
        t1 = m_cnt[L_T1];
        t2 = m_cnt[L_T2];
        b1 = m_cnt[L_B1];
        b2 = m_cnt[L_B2];
        i = lookup(L_T1, k);
        if (i >= 0) begin
            unlink(i); link_mru(i, L_T2); return 1;
        end
        i = lookup(L_T2, k);
        if (i >= 0) begin
            unlink(i); link_mru(i, L_T2); return 2;
        end
        i = lookup(L_B1, k);
        if (i >= 0) begin
            d = (b1 != 0) ? b2 / b1 : 1;
            if (d < 1) d = 1;
            m_target = (m_target + d > c) ? c : m_target + d;
            make_room(1'b0);
            unlink(i); link_mru(i, L_T2); return 3;
        end
        i = lookup(L_B2, k);
        if (i >= 0) begin
            d = (b2 != 0) ? b1 / b2 : 1;
            if (d < 1) d = 1;
            m_target = (m_target > d) ? m_target - d : 0;
            make_room(1'b1);
            unlink(i); link_mru(i, L_T2); return 4;
        end
        // plain miss
        if (t1 + b1 >= c) begin
            if (t1 < c) begin
                dummy = drop_oldest(L_B1);
                make_room(1'b0);
            end else begin
                dummy = drop_oldest(L_T1);
            end
        end else if (t1 + b1 + t2 + b2 >= c) begin
            if (t1 + b1 + t2 + b2 >= 2 * c) dummy = drop_oldest(L_B2);
            make_room(1'b0);
        end
        i = free_slot();
        if (i < 0) begin
            if (!drop_oldest(L_B2) && !drop_oldest(L_B1) && !drop_oldest(L_T2))
                dummy = drop_oldest(L_T1);
            i = free_slot();
            if (i < 0) return 0;
        end
        m_key[i]   = k;
        m_valid[i] = 1'b1;
        link_mru(i, L_T1);
        return 0;
    endfunction

    function automatic int arc_remove(logic [31:0] k);
        int    hc;
        int    i;
        t_list l;
        hc = 0;
        for (int li = 0; li < 4; li++) begin
            l = t_list'(li);
            i = lookup(l, k);
            while (i >= 0) begin
                if (hc == 0) hc = li + 1;
                unlink(i);
                m_valid[i] = 1'b0;
                if (l == L_T1 || l == L_T2) note_evict(k);
                i = lookup(l, k);
            end
        end
        return hc;
    endfunction

    function automatic t_rsp arc_predict(t_req r);
        t_rsp o;
        int   hc;
        hc       = 0;
        m_ev     = 1'b0;
        m_ev_key = '0;
        case (r.kind)
            K_ACCESS: hc = arc_access(r.key);
            K_REMOVE: hc = arc_remove(r.key);
            K_EVICT: begin
                if (m_cnt[L_T1] > 0) demote(L_T1, L_B1);
                else if (m_cnt[L_T2] > 0) demote(L_T2, L_B2);
            end
            default: ;
        endcase
        o.hit_class      = hc[2:0];
        o.evict_valid    = m_ev;
        o.evict_key      = m_ev ? m_ev_key : '0;
        o.cache_nonempty = (m_cnt[L_T1] + m_cnt[L_T2]) > 0;
        o.adapt_target   = m_target[6:0];
        return o;
    endfunction

    // ---------------- clock, reset, bookkeeping ----------------
    t_req  pending_reqs [$];
    t_rsp  expected_rsps [$];
    int    errors;
    int    cycles;
    bit    quiet;
    bit    req_taken;
    bit    hold_go;
    bit    hold_done;
    int    hold_left;
    int    send_gap;
    int    recv_gap;
    logic [31:0] key_pool [160];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    // cycle limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk) begin
        if (hold_go && !hold_done && hold_left == 0) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // request driver
    always @(negedge clk) begin
        if (rst_n && (!req_if.valid || req_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                req_if.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(0, 11);
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                t_req r;
                r = pending_reqs.pop_front();
                req_if.valid <= 1'b1;
                req_if.kind  <= r.kind;
                req_if.key   <= r.key;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // response ready
    always @(negedge clk) begin
        if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap <= $urandom_range(0, 11);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // monitor: predict on request transfer, check on response transfer
    always @(posedge clk) begin
        req_taken <= req_if.valid && req_if.ready;
        if (rst_n && req_if.valid && req_if.ready) begin
            t_req r;
            r.kind = req_if.kind;
            r.key  = req_if.key;
            expected_rsps.push_back(arc_predict(r));
        end
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
                mismatch("unexpected response", rsp_if.hit_class, 0);
            end else begin
                t_rsp e;
                e = expected_rsps.pop_front();
                if (rsp_if.hit_class !== e.hit_class)
                    mismatch("hit_class", rsp_if.hit_class, e.hit_class);
                if (rsp_if.evict_valid !== e.evict_valid)
                    mismatch("evict_valid", rsp_if.evict_valid, e.evict_valid);
                if (rsp_if.evict_key !== e.evict_key)
                    mismatch("evict_key", rsp_if.evict_key, e.evict_key);
                if (rsp_if.cache_nonempty !== e.cache_nonempty)
                    mismatch("cache_nonempty", rsp_if.cache_nonempty, e.cache_nonempty);
                if (rsp_if.adapt_target !== e.adapt_target)
                    mismatch("adapt_target", rsp_if.adapt_target, e.adapt_target);
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic push_req(logic [1:0] kind, logic [31:0] key);
        t_req r;
        r.kind = kind;
        r.key  = key;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && !req_if.valid && expected_rsps.size() == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_size(logic [6:0] v);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        m_size = int'(v);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // mostly keys from a working set sized to the capacity, some wild ones
    task automatic random_reqs(int n);
        int          sel;
        int          span;
        logic [1:0]  kind;
        logic [31:0] key;
        span = 2 * cap_eff() + 8;
        if (span > 160) span = 160;
        for (int j = 0; j < n; j++) begin
            sel = $urandom_range(0, 99);
            if (sel < 72)      kind = K_ACCESS;
            else if (sel < 84) kind = K_REMOVE;
            else if (sel < 95) kind = K_EVICT;
            else               kind = KIND_UNUSED;
            if ($urandom_range(0, 99) < 88) key = key_pool[$urandom_range(0, span - 1)];
            else                            key = $urandom;
            push_req(kind, key);
        end
    endtask

    initial begin
        logic [6:0] sizes [8];
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.kind   = K_ACCESS;
        req_if.key    = '0;
        rsp_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        errors = 0; cycles = 0; quiet = 0; req_taken = 0;
        hold_go = 0; hold_done = 0; hold_left = 0; send_gap = 0; recv_gap = 0;
        for (int i = 0; i < POOL; i++) m_valid[i] = 1'b0;
        for (int l = 0; l < 4; l++) begin
            m_head[l] = 0; m_tail[l] = 0; m_cnt[l] = 0;
        end
        m_target = 0;
        m_size   = CFG_RESET;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 160; i++) key_pool[i] = $urandom;
        sizes = '{7'd1, 7'd64, 7'd2, 7'd0, 7'd127, 7'd5, 7'd20, 7'd3};

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty evict, extreme keys, T1 then T2 hit, removes, unused kind
        push_req(K_EVICT, 32'h0);
        push_req(K_ACCESS, 32'h0);
        push_req(K_ACCESS, 32'hFFFF_FFFF);
        push_req(K_ACCESS, 32'h0);
        push_req(K_ACCESS, 32'h0);
        push_req(K_REMOVE, 32'hFFFF_FFFF);
        push_req(K_REMOVE, 32'h1234_5678);
        push_req(KIND_UNUSED, 32'h5);
        // overflow the default capacity, then come back to a ghost
        for (int k = 1; k <= 11; k++) push_req(K_ACCESS, k);
        push_req(K_ACCESS, 32'h1);
        push_req(K_EVICT, 32'h0);
        push_req(K_EVICT, 32'h0);
        push_req(K_ACCESS, 32'h0);
        push_req(K_REMOVE, 32'h1);
        random_reqs(45);
        wait_idle();

        // one phase per capacity setting, the last without idling
        for (int ph = 0; ph < 8; ph++) begin
            write_size(sizes[ph]);
            if (ph == 1) hold_go = 1'b1;
            if (ph == 7) quiet = 1'b1;
            random_reqs(sizes[ph] >= 20 ? 80 : 55);
            wait_idle();
        end
        // random setting to finish, still without idling
        write_size($urandom_range(1, 64));
        random_reqs(40);
        wait_idle();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[adaptive_replacement_cache_policy_top.f]
hdl/arcp_pkg.sv
hdl/arcp_if.sv
hdl/arcp_cell.sv
hdl/arcp_array.sv
hdl/arcp_div.sv
hdl/adaptive_replacement_cache_policy_top.sv
bench/tb_top.sv
